[sv/atac_pkg.sv]
`timescale 1ns / 1ps

package atac_pkg;

    // raw converter reading width
    localparam int SAMPLE_BITS = 10;

    // vectoring iterations of each angle lane
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 16;
    localparam int ATAN_LEN     = 24;

    // linear map onto -90..90
    localparam int SCALE_SPAN   = 180;
    localparam int SCALE_OFFSET = 90;
    localparam int SCALED_MAX   = 127;
    localparam int SCALED_MIN   = -128;

    // quotient magnitudes past these saturate
    localparam int SAT_POS_Q = SCALED_MAX + SCALE_OFFSET;
    localparam int SAT_NEG_Q = -SCALED_MIN - SCALE_OFFSET;

    // quotient bits kept by the divider, enough to cover both saturation points
    localparam int QBITS = 9;

    // numerator width, |s - lo| * 180
    localparam int NW = SAMPLE_BITS + 8;

    // pipeline depths
    localparam int SC_STAGES = QBITS + 2;
    localparam int CD_STAGES = CORDIC_STEPS + 2;
    localparam int NUM_STAGES = SC_STAGES + CD_STAGES;

    // datapath widths of the angle lane
    localparam int XW = FRAC_BITS + 10;
    localparam int ZW = FRAC_BITS + 9;
    localparam int RW = FRAC_BITS + 11;
    localparam int DEG_BITS = 9;
    localparam int SCALED_BITS = 8;

    localparam int DEG_HALF  = 180;
    localparam int DEG_QTR   = 90;
    localparam int DEG_3QTR  = 270;
    localparam int DEG_FULL  = 360;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAL_MIN = 2'd0,
        CFG_CAL_MAX = 2'd1
    } t_cfg_idx;

    localparam logic [SAMPLE_BITS-1:0] CAL_MIN_RST = SAMPLE_BITS'(265);
    localparam logic [SAMPLE_BITS-1:0] CAL_MAX_RST = SAMPLE_BITS'(413);

    // round(atan(2^-i) in degrees * 2^16)
    localparam logic [22:0] ATAN_Q16 [0:ATAN_LEN-1] = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
        23'd234378,  23'd117305,  23'd58666,  23'd29335,
        23'd14668,   23'd7334,    23'd3667,   23'd1833,
        23'd917,     23'd458,     23'd229,    23'd115,
        23'd57,      23'd29,      23'd14,     23'd7,
        23'd4,       23'd2,       23'd1,      23'd0
    };

    typedef struct packed {
        logic signed [SCALED_BITS-1:0] x;
        logic signed [SCALED_BITS-1:0] y;
        logic signed [SCALED_BITS-1:0] z;
    } t_scaled3;

endpackage

[sv/atac_scale.sv]
`timescale 1ns / 1ps

module atac_scale (
    input  logic                                    i_clk,
    input  logic [atac_pkg::SC_STAGES-1:0]          i_en,
    input  logic [atac_pkg::SAMPLE_BITS-1:0]        i_sample,
    input  logic [atac_pkg::SAMPLE_BITS-1:0]        i_cal_min,
    input  logic [atac_pkg::SAMPLE_BITS-1:0]        i_cal_max,
    output logic signed [atac_pkg::SCALED_BITS-1:0] o_scaled
);
    import atac_pkg::*;

    logic [NW-1:0]          r_rem   [0:QBITS];
    logic [QBITS-1:0]       r_q     [0:QBITS];
    logic [SAMPLE_BITS-1:0] r_d     [0:QBITS];
    logic                   r_neg   [0:QBITS];
    logic                   r_empty [0:QBITS];
    logic                   r_ovf   [0:QBITS];
    logic signed [SCALED_BITS-1:0] r_out;

    logic signed [SAMPLE_BITS:0] n_diff;
    logic [SAMPLE_BITS-1:0]      n_mag;
    logic [NW-1:0]               n_num;
    logic [NW:0]                 n_trial [1:QBITS];
    logic                        n_ovf;
    logic [QBITS-1:0]            n_qf;
    logic signed [QBITS+1:0]     n_v;
    logic signed [SCALED_BITS-1:0] n_out;

    // stage 0: signed offset into the window, times the span
    always_comb begin
        n_diff = $signed({1'b0, i_sample}) - $signed({1'b0, i_cal_min});
        n_mag  = n_diff[SAMPLE_BITS] ? SAMPLE_BITS'(-n_diff) : n_diff[SAMPLE_BITS-1:0];
        n_num  = NW'(n_mag) * NW'(SCALE_SPAN);
    end

    // one restoring quotient bit per stage
    always_comb begin
        for (int k = 1; k <= QBITS; k++) begin
            n_trial[k] = {1'b0, r_rem[k-1]} - ((NW+1)'(r_d[k-1]) << (QBITS - k));
        end
        n_ovf = {1'b0, r_rem[0]} >= ((NW+1)'(r_d[0]) << QBITS);
    end

    // truncating quotient, then offset and saturate; an empty window gives zero
    always_comb begin
        n_qf = r_q[QBITS];
        n_v  = '0;
        if (r_empty[QBITS]) begin
            n_out = '0;
        end else if (!r_neg[QBITS]) begin
            if (r_ovf[QBITS] || n_qf > QBITS'(SAT_POS_Q)) begin
                n_out = SCALED_BITS'(SCALED_MAX);
            end else begin
                n_v   = $signed({2'b00, n_qf}) - (QBITS+2)'(SCALE_OFFSET);
                n_out = n_v[SCALED_BITS-1:0];
            end
        end else begin
            if (r_ovf[QBITS] || n_qf > QBITS'(SAT_NEG_Q)) begin
                n_out = SCALED_BITS'(SCALED_MIN);
            end else begin
                n_v   = -$signed({2'b00, n_qf}) - (QBITS+2)'(SCALE_OFFSET);
                n_out = n_v[SCALED_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0]   <= n_num;
            r_q[0]     <= '0;
            r_d[0]     <= i_cal_max - i_cal_min;
            r_neg[0]   <= n_diff[SAMPLE_BITS];
            r_empty[0] <= i_cal_max <= i_cal_min;
            r_ovf[0]   <= 1'b0;
        end
        for (int k = 1; k <= QBITS; k++) begin
            if (i_en[k]) begin
                r_d[k]     <= r_d[k-1];
                r_neg[k]   <= r_neg[k-1];
                r_empty[k] <= r_empty[k-1];
                r_ovf[k]   <= (k == 1) ? n_ovf : r_ovf[k-1];
                if (!n_trial[k][NW]) begin
                    r_rem[k] <= n_trial[k][NW-1:0];
                    r_q[k]   <= r_q[k-1] | (QBITS'(1) << (QBITS - k));
                end else begin
                    r_rem[k] <= r_rem[k-1];
                    r_q[k]   <= r_q[k-1];
                end
            end
        end
        if (i_en[QBITS+1]) begin
            r_out <= n_out;
        end
    end

    assign o_scaled = r_out;

endmodule

[sv/atac_cordic.sv]
`timescale 1ns / 1ps

module atac_cordic (
    input  logic                                    i_clk,
    input  logic [atac_pkg::CD_STAGES-1:0]          i_en,
    input  logic signed [atac_pkg::SCALED_BITS-1:0] i_a,
    input  logic signed [atac_pkg::SCALED_BITS-1:0] i_b,
    output logic [atac_pkg::DEG_BITS-1:0]           o_deg
);
    import atac_pkg::*;

    logic signed [XW-1:0]  r_x    [0:CORDIC_STEPS];
    logic signed [XW-1:0]  r_y    [0:CORDIC_STEPS];
    logic signed [ZW-1:0]  r_z    [0:CORDIC_STEPS];
    logic                  r_spec [0:CORDIC_STEPS];
    logic [DEG_BITS-1:0]   r_sdeg [0:CORDIC_STEPS];
    logic                  r_xpos [0:CORDIC_STEPS];
    logic                  r_ypos [0:CORDIC_STEPS];
    logic [DEG_BITS-1:0]   r_deg;

    logic signed [SCALED_BITS:0] n_xs;
    logic signed [SCALED_BITS:0] n_ys;
    logic [SCALED_BITS:0]        n_ax;
    logic [SCALED_BITS:0]        n_ay;
    logic                        n_spec;
    logic [DEG_BITS-1:0]         n_sdeg;
    logic signed [ZW-1:0]        n_zc;
    logic signed [RW-1:0]        n_r;
    logic signed [RW-FRAC_BITS-1:0] n_ri;
    logic [DEG_BITS-1:0]         n_deg;

    // stage 0: negate, fold into first quadrant, catch zero components
    always_comb begin
        n_ys = -$signed({i_a[SCALED_BITS-1], i_a});
        n_xs = -$signed({i_b[SCALED_BITS-1], i_b});
        n_ax = n_xs[SCALED_BITS] ? (SCALED_BITS+1)'(-n_xs) : n_xs;
        n_ay = n_ys[SCALED_BITS] ? (SCALED_BITS+1)'(-n_ys) : n_ys;
        n_spec = 1'b1;
        if (n_xs == '0 && n_ys == '0) begin
            n_sdeg = DEG_BITS'(DEG_HALF);
        end else if (n_ys == '0) begin
            n_sdeg = n_xs > 0 ? DEG_BITS'(DEG_HALF) : DEG_BITS'(DEG_FULL);
        end else if (n_xs == '0) begin
            n_sdeg = n_ys > 0 ? DEG_BITS'(DEG_3QTR) : DEG_BITS'(DEG_QTR);
        end else begin
            n_spec = 1'b0;
            n_sdeg = '0;
        end
    end

    // last stage: clamp angle, map quadrant, drop fraction
    always_comb begin
        n_zc = r_z[CORDIC_STEPS];
        if (n_zc < 0) begin
            n_zc = '0;
        end else if (n_zc > (ZW'(DEG_QTR) <<< FRAC_BITS)) begin
            n_zc = ZW'(DEG_QTR) <<< FRAC_BITS;
        end
        if (r_xpos[CORDIC_STEPS]) begin
            n_r = r_ypos[CORDIC_STEPS] ? (RW'(DEG_HALF) <<< FRAC_BITS) + RW'(n_zc)
                                       : (RW'(DEG_HALF) <<< FRAC_BITS) - RW'(n_zc);
        end else begin
            n_r = r_ypos[CORDIC_STEPS] ? (RW'(DEG_FULL) <<< FRAC_BITS) - RW'(n_zc)
                                       : RW'(n_zc);
        end
        n_ri = n_r[RW-1:FRAC_BITS];
        if (r_spec[CORDIC_STEPS]) begin
            n_deg = r_sdeg[CORDIC_STEPS];
        end else if (n_ri > (RW-FRAC_BITS)'(DEG_FULL)) begin
            n_deg = DEG_BITS'(DEG_FULL);
        end else begin
            n_deg = n_ri[DEG_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= XW'(n_ax) <<< FRAC_BITS;
            r_y[0]    <= XW'(n_ay) <<< FRAC_BITS;
            r_z[0]    <= '0;
            r_spec[0] <= n_spec;
            r_sdeg[0] <= n_sdeg;
            r_xpos[0] <= n_xs > 0;
            r_ypos[0] <= n_ys > 0;
        end
        // one micro-rotation toward y = 0 per stage
        for (int k = 1; k <= CORDIC_STEPS; k++) begin
            if (i_en[k]) begin
                r_spec[k] <= r_spec[k-1];
                r_sdeg[k] <= r_sdeg[k-1];
                r_xpos[k] <= r_xpos[k-1];
                r_ypos[k] <= r_ypos[k-1];
                if (r_y[k-1] > 0) begin
                    r_x[k] <= r_x[k-1] + (r_y[k-1] >>> (k - 1));
                    r_y[k] <= r_y[k-1] - (r_x[k-1] >>> (k - 1));
                    r_z[k] <= r_z[k-1] + ZW'(ATAN_Q16[k-1]);
                end else if (r_y[k-1] < 0) begin
                    r_x[k] <= r_x[k-1] - (r_y[k-1] >>> (k - 1));
                    r_y[k] <= r_y[k-1] + (r_x[k-1] >>> (k - 1));
                    r_z[k] <= r_z[k-1] - ZW'(ATAN_Q16[k-1]);
                end else begin
                    r_x[k] <= r_x[k-1];
                    r_y[k] <= r_y[k-1];
                    r_z[k] <= r_z[k-1];
                end
            end
        end
        if (i_en[CORDIC_STEPS+1]) begin
            r_deg <= n_deg;
        end
    end

    assign o_deg = r_deg;

endmodule

[sv/accel_tilt_angle_calc_unit.sv]
`timescale 1ns / 1ps

// channel  | handshake                      | payload
// ---------+--------------------------------+---------------------------------------
// input    | i_in_valid / o_in_ready        | i_x_sample, i_y_sample, i_z_sample
// output   | o_out_valid / i_out_ready      | o_{x,y,z}_scaled, o_{x,y,z}_tilt_deg
// config   | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one word per cycle sustained while i_out_ready stays high; each word passes through
// 29 registers (11 stages of scaling divider, 16 cordic stages, one prep and one output stage)
// synchronous active-low reset clears the stage valid bits and loads default calibration
// each stage holds while its successor is full and stalled, so bubbles still fill
// under output stall and a finished word waits in the output stage without blocking input

module accel_tilt_angle_calc_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [atac_pkg::SAMPLE_BITS-1:0]        i_x_sample,
    input  logic [atac_pkg::SAMPLE_BITS-1:0]        i_y_sample,
    input  logic [atac_pkg::SAMPLE_BITS-1:0]        i_z_sample,

    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [atac_pkg::SCALED_BITS-1:0] o_x_scaled,
    output logic signed [atac_pkg::SCALED_BITS-1:0] o_y_scaled,
    output logic signed [atac_pkg::SCALED_BITS-1:0] o_z_scaled,
    output logic [atac_pkg::DEG_BITS-1:0]           o_x_tilt_deg,
    output logic [atac_pkg::DEG_BITS-1:0]           o_y_tilt_deg,
    output logic [atac_pkg::DEG_BITS-1:0]           o_z_tilt_deg,

    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [atac_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [atac_pkg::SAMPLE_BITS-1:0]        i_cfg_data
);
    import atac_pkg::*;

    // calibration window
    logic [SAMPLE_BITS-1:0] r_cal_min;
    logic [SAMPLE_BITS-1:0] r_cal_max;

    // per-stage occupancy and advance enables
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES:0]   n_en;

    // scaled values riding alongside the angle lanes
    t_scaled3 r_dly [0:CD_STAGES-1];
    t_scaled3 n_scaled;

    always_comb begin
        n_en[NUM_STAGES] = i_out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_in_ready  = n_en[0];
    assign o_out_valid = r_v[NUM_STAGES-1];
    assign o_cfg_ready = 1'b1;

    // valid bits shift with the enables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // config register writes, index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_min <= CAL_MIN_RST;
            r_cal_max <= CAL_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CAL_MIN: r_cal_min <= i_cfg_data;
                CFG_CAL_MAX: r_cal_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // three scaling lanes
    atac_scale u_scale_x (
        .i_clk     (i_clk),
        .i_en      (n_en[SC_STAGES-1:0]),
        .i_sample  (i_x_sample),
        .i_cal_min (r_cal_min),
        .i_cal_max (r_cal_max),
        .o_scaled  (n_scaled.x)
    );

    atac_scale u_scale_y (
        .i_clk     (i_clk),
        .i_en      (n_en[SC_STAGES-1:0]),
        .i_sample  (i_y_sample),
        .i_cal_min (r_cal_min),
        .i_cal_max (r_cal_max),
        .o_scaled  (n_scaled.y)
    );

    atac_scale u_scale_z (
        .i_clk     (i_clk),
        .i_en      (n_en[SC_STAGES-1:0]),
        .i_sample  (i_z_sample),
        .i_cal_min (r_cal_min),
        .i_cal_max (r_cal_max),
        .o_scaled  (n_scaled.z)
    );

    // three angle lanes, each pairs two of the scaled axes
    atac_cordic u_cordic_x (
        .i_clk (i_clk),
        .i_en  (n_en[NUM_STAGES-1:SC_STAGES]),
        .i_a   (n_scaled.y),
        .i_b   (n_scaled.z),
        .o_deg (o_x_tilt_deg)
    );

    atac_cordic u_cordic_y (
        .i_clk (i_clk),
        .i_en  (n_en[NUM_STAGES-1:SC_STAGES]),
        .i_a   (n_scaled.x),
        .i_b   (n_scaled.z),
        .o_deg (o_y_tilt_deg)
    );

    atac_cordic u_cordic_z (
        .i_clk (i_clk),
        .i_en  (n_en[NUM_STAGES-1:SC_STAGES]),
        .i_a   (n_scaled.y),
        .i_b   (n_scaled.x),
        .o_deg (o_z_tilt_deg)
    );

    // merge: delay the scaled word to line up with the angles
    always_ff @(posedge i_clk) begin
        if (n_en[SC_STAGES]) begin
            r_dly[0] <= n_scaled;
        end
        for (int k = 1; k < CD_STAGES; k++) begin
            if (n_en[SC_STAGES+k]) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    assign o_x_scaled = r_dly[CD_STAGES-1].x;
    assign o_y_scaled = r_dly[CD_STAGES-1].y;
    assign o_z_scaled = r_dly[CD_STAGES-1].z;

`ifndef SYNTH
    // an empty output stage always leaves room at the input
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // words in flight change only by accepts on either side
    a_word_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        ($countones(r_v) + $past(int'(o_out_valid && i_out_ready))
         == $past($countones(r_v)) + $past(int'(i_in_valid && o_in_ready))))
        else $error("word lost or duplicated in pipeline");

    // angles never leave 0..360
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_x_tilt_deg <= DEG_BITS'(DEG_FULL)
                      && o_y_tilt_deg <= DEG_BITS'(DEG_FULL)
                      && o_z_tilt_deg <= DEG_BITS'(DEG_FULL)))
        else $error("tilt angle out of range");
`endif

endmodule

[tb/tb_accel_tilt_angle_calc_unit.sv]
`timescale 1ns / 1ps

module tb_accel_tilt_angle_calc_unit;
    import atac_pkg::*;

    typedef logic [SAMPLE_BITS-1:0] t_raw;

    typedef struct packed {
        t_raw x;
        t_raw y;
        t_raw z;
    } t_triple;

    typedef struct packed {
        logic signed [SCALED_BITS-1:0] xs;
        logic signed [SCALED_BITS-1:0] ys;
        logic signed [SCALED_BITS-1:0] zs;
        logic [DEG_BITS-1:0]           xd;
        logic [DEG_BITS-1:0]           yd;
        logic [DEG_BITS-1:0]           zd;
    } t_tilt_word;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_raw i_x_sample;
    t_raw i_y_sample;
    t_raw i_z_sample;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [SCALED_BITS-1:0] o_x_scaled;
    logic signed [SCALED_BITS-1:0] o_y_scaled;
    logic signed [SCALED_BITS-1:0] o_z_scaled;
    logic [DEG_BITS-1:0] o_x_tilt_deg;
    logic [DEG_BITS-1:0] o_y_tilt_deg;
    logic [DEG_BITS-1:0] o_z_tilt_deg;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_raw i_cfg_data;

    // calibration as the predictor sees it
    t_raw win_lo;
    t_raw win_hi;

    // sample words waiting for the driver, expected result words
    t_triple    sample_q[$];
    t_tilt_word tilt_q[$];

    int  mismatch_cnt;
    int  send_gap;
    int  recv_gap;
    int  recv_draw;     // stall drawn for the next result word
    bit  hold_off;      // long output stall requested by the stimulus
    bit  idle_ok;       // random idling enabled
    bit  stim_done;

    accel_tilt_angle_calc_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // --------------------------------------------------------------------
    // predictor
    // --------------------------------------------------------------------

    // linear map of one raw reading onto -90..90, saturated to a signed byte
    function automatic logic signed [7:0] scale_raw(t_raw s);
        longint lo, hi, v;
        lo = win_lo;
        hi = win_hi;
        if (hi <= lo)
            return 8'sd0;
        v = ((longint'(s) - lo) * SCALE_SPAN) / (hi - lo) - SCALE_OFFSET;  // truncates toward zero
        if (v > SCALED_MAX)
            v = SCALED_MAX;
        if (v < SCALED_MIN)
            v = SCALED_MIN;
        return 8'(v);
    endfunction

    // atan2(-a, -b) + pi in whole degrees via vectoring cordic
    function automatic logic [8:0] tilt_of(logic signed [7:0] a, logic signed [7:0] b);
        longint ys, xs, x, y, z, r, dx, dy;
        longint lut [0:23];
        lut = '{2949120, 1740967, 919879, 466945, 234378, 117305, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115,
                57, 29, 14, 7, 4, 2, 1, 0};
        ys = -longint'(a);
        xs = -longint'(b);
        if (xs == 0 && ys == 0)
            return 9'(DEG_HALF);
        if (ys == 0)
            return xs > 0 ? 9'(DEG_HALF) : 9'(DEG_FULL);
        if (xs == 0)
            return ys > 0 ? 9'(DEG_3QTR) : 9'(DEG_QTR);
        x = (xs < 0 ? -xs : xs) <<< FRAC_BITS;
        y = (ys < 0 ? -ys : ys) <<< FRAC_BITS;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += lut[i];
            end else if (y < 0) begin
                x -= dx;
                y += dy;
                z -= lut[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > (longint'(DEG_QTR) <<< FRAC_BITS))
            z = longint'(DEG_QTR) <<< FRAC_BITS;
        if (xs > 0)
            r = ys > 0 ? (longint'(DEG_HALF) <<< FRAC_BITS) + z
                       : (longint'(DEG_HALF) <<< FRAC_BITS) - z;
        else
            r = ys > 0 ? (longint'(DEG_FULL) <<< FRAC_BITS) - z : z;
        r = r >>> FRAC_BITS;
        if (r > DEG_FULL)
            r = DEG_FULL;
        return 9'(r);
    endfunction

    function automatic t_tilt_word predict_tilt(t_triple t);
        t_tilt_word w;
        w.xs = scale_raw(t.x);
        w.ys = scale_raw(t.y);
        w.zs = scale_raw(t.z);
        w.xd = tilt_of(w.ys, w.zs);
        w.yd = tilt_of(w.xs, w.zs);
        w.zd = tilt_of(w.ys, w.xs);
        return w;
    endfunction

    // --------------------------------------------------------------------
    // driver: one word from sample_q per handshake, random gap per word
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                tilt_q.push_back(predict_tilt({i_x_sample, i_y_sample, i_z_sample}));
            if (!i_in_valid || o_in_ready) begin
                // slot is free this edge: either wait out the gap or load the next word
                if (send_gap > 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    t_triple t;
                    t = sample_q.pop_front();
                    i_x_sample <= t.x;
                    i_y_sample <= t.y;
                    i_z_sample <= t.z;
                    i_in_valid <= 1'b1;
                    send_gap   <= idle_ok ? $urandom_range(0, 18) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // monitor: checks every accepted result word, random stall per word
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            recv_gap     <= 0;
            mismatch_cnt <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                t_tilt_word got;
                t_tilt_word want;
                got = {o_x_scaled, o_y_scaled, o_z_scaled,
                       o_x_tilt_deg, o_y_tilt_deg, o_z_tilt_deg};
                if (tilt_q.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result word %p", got);
                    mismatch_cnt <= mismatch_cnt + 1;
                end else begin
                    want = tilt_q.pop_front();
                    if (got !== want) begin
                        if (mismatch_cnt < 10)
                            $display("mismatch: expected %p got %p", want, got);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
                // zero stall keeps ready up for a back to back word
                recv_draw = idle_ok ? $urandom_range(0, 18) : 0;
                recv_gap    <= recv_draw;
                i_out_ready <= (recv_draw == 0) && !hold_off;
            end else if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap    <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // --------------------------------------------------------------------
    // stimulus
    // --------------------------------------------------------------------
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((sample_q.size() > 0 || i_in_valid || tilt_q.size() > 0) && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        // pipeline depth plus margin
        repeat (NUM_STAGES + 20) @(posedge i_clk);
    endtask

    task automatic write_cal(t_cfg_idx idx, t_raw val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_CAL_MIN)
            win_lo = val;
        else
            win_hi = val;
    endtask

    // mostly samples around the window so the map is well exercised
    function automatic t_raw rand_raw();
        int lo, hi;
        if ($urandom_range(0, 9) < 7 && win_hi > win_lo) begin
            lo = int'(win_lo) - 20;
            hi = int'(win_hi) + 20;
            if (lo < 0)
                lo = 0;
            if (hi > 1023)
                hi = 1023;
            return t_raw'($urandom_range(lo, hi));
        end
        return t_raw'($urandom_range(0, 1023));
    endfunction

    task automatic push_random(int n);
        repeat (n)
            sample_q.push_back({rand_raw(), rand_raw(), rand_raw()});
    endtask

    initial begin
        t_raw mid;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_x_sample  = '0;
        i_y_sample  = '0;
        i_z_sample  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CAL_MIN;
        i_cfg_data  = '0;
        win_lo      = CAL_MIN_RST;
        win_hi      = CAL_MAX_RST;
        hold_off    = 1'b0;
        idle_ok     = 1'b0;
        stim_done   = 1'b0;
        recv_draw   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset calibration: window edges, center, zero components, extremes
        mid = t_raw'((CAL_MIN_RST + CAL_MAX_RST) / 2);
        sample_q.push_back({CAL_MIN_RST, CAL_MIN_RST, CAL_MIN_RST});
        sample_q.push_back({CAL_MAX_RST, CAL_MAX_RST, CAL_MAX_RST});
        sample_q.push_back({mid, mid, mid});
        sample_q.push_back({mid, mid, CAL_MAX_RST});
        sample_q.push_back({mid, mid, CAL_MIN_RST});
        sample_q.push_back({mid, CAL_MAX_RST, mid});
        sample_q.push_back({mid, CAL_MIN_RST, mid});
        sample_q.push_back({CAL_MAX_RST, mid, mid});
        sample_q.push_back({CAL_MIN_RST, mid, CAL_MAX_RST});
        sample_q.push_back({t_raw'(0), t_raw'(1023), t_raw'(0)});
        sample_q.push_back({t_raw'(1023), t_raw'(0), t_raw'(1023)});
        sample_q.push_back({t_raw'(10'h2AA), t_raw'(10'h155), t_raw'(10'h3FF)});
        wait_drained();

        // empty window: everything scales to zero
        write_cal(CFG_CAL_MIN, t_raw'(500));
        write_cal(CFG_CAL_MAX, t_raw'(500));
        sample_q.push_back({t_raw'(0), t_raw'(500), t_raw'(1023)});
        sample_q.push_back({t_raw'(1023), t_raw'(1), t_raw'(700)});
        wait_drained();
        write_cal(CFG_CAL_MAX, t_raw'(200));
        sample_q.push_back({t_raw'(100), t_raw'(300), t_raw'(900)});
        wait_drained();

        // random phase under several windows, extremes included
        idle_ok = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin write_cal(CFG_CAL_MIN, CAL_MIN_RST); write_cal(CFG_CAL_MAX, CAL_MAX_RST); end
                1: begin write_cal(CFG_CAL_MIN, t_raw'(0));   write_cal(CFG_CAL_MAX, t_raw'(1023)); end
                2: begin write_cal(CFG_CAL_MIN, t_raw'(0));   write_cal(CFG_CAL_MAX, t_raw'(1)); end
                3: begin write_cal(CFG_CAL_MIN, t_raw'(1022)); write_cal(CFG_CAL_MAX, t_raw'(1023)); end
                4: begin write_cal(CFG_CAL_MIN, t_raw'(1023)); write_cal(CFG_CAL_MAX, t_raw'(0)); end
                default: begin
                    write_cal(CFG_CAL_MIN, t_raw'($urandom_range(0, 600)));
                    write_cal(CFG_CAL_MAX, t_raw'($urandom_range(win_lo, 1023)));
                end
            endcase
            if (ph == 0) begin
                // long output stall so the pipeline fills and stalls the input
                idle_ok = 1'b0;
                push_random(60);
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
                idle_ok = 1'b1;
            end
            push_random(240);
            wait_drained();
        end

        // fully back to back stretch
        idle_ok = 1'b0;
        write_cal(CFG_CAL_MIN, t_raw'(100));
        write_cal(CFG_CAL_MAX, t_raw'(900));
        push_random(100);
        wait_drained();

        if (mismatch_cnt == 0 && tilt_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
